FILE: rtl/lq_pkg.sv
// ----------------------------------------------------------------------------
// lq_pkg
// Shared types, codes and sizes for the landing queue with urgent promotion.
// ----------------------------------------------------------------------------
package lq_pkg;

  // Queue size and derived widths.
  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // Field widths.
  localparam int OPW  = 2;
  localparam int FLW  = 14;
  localparam int TAGW = 32;
  localparam int STW  = 2;

  // Command codes carried by an input transfer.
  typedef enum logic [OPW-1:0] {
    OP_REQUEST = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_PROMOTE = 2'd2,
    OP_DRAIN   = 2'd3
  } opcode_t;

  // Status codes carried by a result transfer.
  typedef enum logic [STW-1:0] {
    ST_GIVEN = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  // One queue entry as held in the entry memory.
  typedef struct packed {
    logic [FLW-1:0]  flight;
    logic [TAGW-1:0] tag;
  } entry_t;

  // Read address source.
  typedef enum logic {
    RD_IDX = 1'b0,
    RD_JM1 = 1'b1
  } rd_sel_t;

  // Write address and data source.
  typedef enum logic [1:0] {
    WR_TAIL = 2'd0,
    WR_J    = 2'd1,
    WR_URG  = 2'd2
  } wr_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    start;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    srch_rd;
    logic    idx_inc;
    logic    grab;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    count_inc;
    logic    pop;
    logic    uc_inc;
    logic    j_dec;
    logic    qclear;
    logic    out_load;
    status_t out_code;
    logic    out_data;
    logic    out_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic idx_lt_count;
    logic srch_vld;
    logic srch_hit;
    logic hit_urgent;
    logic j_gt_uc;
    logic drn_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/lq_if.sv
// ----------------------------------------------------------------------------
// lq_if
// Valid/ready channel interfaces for the input commands and the results.
// ----------------------------------------------------------------------------
interface lq_in_if;
  import lq_pkg::*;

  logic            valid;
  logic            ready;
  logic [OPW-1:0]  opcode;
  logic [FLW-1:0]  flight;
  logic [TAGW-1:0] payload;

  modport source (output valid, output opcode, output flight, output payload, input ready);
  modport sink   (input valid, input opcode, input flight, input payload, output ready);
endinterface

interface lq_out_if;
  import lq_pkg::*;

  logic            valid;
  logic            ready;
  logic [STW-1:0]  status;
  logic [FLW-1:0]  out_flight;
  logic [TAGW-1:0] out_payload;
  logic            last;

  modport source (output valid, output status, output out_flight, output out_payload,
                  output last, input ready);
  modport sink   (input valid, input status, input out_flight, input out_payload,
                  input last, output ready);
endinterface

FILE: rtl/landing_queue_with_urgent_promotion.sv
// ----------------------------------------------------------------------------
// landing_queue_with_urgent_promotion
// Ordered landing queue with an urgent section at its front.
//
//   Channel  Port    Direction  Payload
//   input    in_ch   sink       opcode, flight, payload
//   result   out_ch  source     status, out_flight, out_payload, last
//
// One command is in work at a time; in_ch.ready is high while the sequencer
// is idle, also while the last result still waits in the output register.
// Promotion scans one entry per cycle through the memory read port; a hit
// beyond the urgent section shifts the displaced entries up one by one and
// places the hit at the urgent end. Drain reads and emits one entry at a
// time, and reads the next only once the result register has taken the last.
// A stalled result port holds the sequencer where it waits.
// Reset is synchronous and empties the queue at once; entries are not cleared.
// ----------------------------------------------------------------------------
module landing_queue_with_urgent_promotion (
  input  logic     clk,
  input  logic     rst_n,
  lq_in_if.sink    in_ch,
  lq_out_if.source out_ch
);
  import lq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Command sequencer.
  lq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Entry memory, counters and result register.
  lq_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_flight   (in_ch.flight),
    .in_payload  (in_ch.payload),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_status  (out_ch.status),
    .out_flight  (out_ch.out_flight),
    .out_payload (out_ch.out_payload),
    .out_last    (out_ch.last)
  );

endmodule

FILE: rtl/lq_ctrl.sv
// ----------------------------------------------------------------------------
// lq_ctrl
// Sequencer for the landing queue: decodes each command and steps the
// datapath through its memory reads, writes and result transfers.
// ----------------------------------------------------------------------------
module lq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [lq_pkg::OPW-1:0] in_opcode,
  output logic             in_ready,
  input  lq_pkg::dp_stat_t stat,
  output lq_pkg::dp_cmd_t  cmd
);
  import lq_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_REQ     = 11'b000_0000_0010,
    S_CLR_RD  = 11'b000_0000_0100,
    S_CLR_OUT = 11'b000_0000_1000,
    S_SRCH    = 11'b000_0001_0000,
    S_SH_RD   = 11'b000_0010_0000,
    S_SH_WR   = 11'b000_0100_0000,
    S_PLACE   = 11'b000_1000_0000,
    S_DRN_RD  = 11'b001_0000_0000,
    S_DRN_OUT = 11'b010_0000_0000,
    S_EMIT    = 11'b100_0000_0000
  } state_t;

  state_t  state_r, state_nxt;
  status_t code_r, code_nxt;

  assign in_ready = (state_r == S_IDLE);

  // State and pending status code registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_NONE;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.rd_sel   = RD_IDX;
    cmd.wr_sel   = WR_TAIL;
    cmd.out_code = code_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          case (opcode_t'(in_opcode))
            OP_REQUEST: state_nxt = S_REQ;
            OP_CLEAR:   state_nxt = S_CLR_RD;
            OP_PROMOTE: state_nxt = S_SRCH;
            default:    state_nxt = S_DRN_RD;
          endcase
        end
      end
      S_REQ: begin
        // Append at the tail unless the queue is full.
        if (stat.full) begin
          code_nxt = ST_FULL;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = WR_TAIL;
          cmd.count_inc = 1'b1;
          code_nxt      = ST_NONE;
        end
        state_nxt = S_EMIT;
      end
      S_CLR_RD: begin
        if (stat.empty) begin
          code_nxt  = ST_EMPTY;
          state_nxt = S_EMIT;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CLR_OUT;
        end
      end
      S_CLR_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_code = ST_GIVEN;
          cmd.out_data = 1'b1;
          cmd.out_last = 1'b1;
          cmd.pop      = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SRCH: begin
        // Pipelined scan: one read issued per cycle, compared in the cycle after.
        if (stat.srch_hit) begin
          if (stat.hit_urgent) begin
            code_nxt  = ST_NONE;
            state_nxt = S_EMIT;
          end else begin
            cmd.grab  = 1'b1;
            state_nxt = S_SH_RD;
          end
        end else if (!stat.srch_vld && !stat.idx_lt_count) begin
          code_nxt  = ST_NONE;
          state_nxt = S_EMIT;
        end else if (stat.idx_lt_count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_IDX;
          cmd.srch_rd = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_SH_RD: begin
        // Shift the entries between the urgent end and the hit up by one.
        if (stat.j_gt_uc) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_JM1;
          state_nxt  = S_SH_WR;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_SH_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_J;
        cmd.j_dec  = 1'b1;
        state_nxt  = S_SH_RD;
      end
      S_PLACE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_URG;
        cmd.uc_inc = 1'b1;
        code_nxt   = ST_NONE;
        state_nxt  = S_EMIT;
      end
      S_DRN_RD: begin
        if (stat.empty) begin
          code_nxt  = ST_EMPTY;
          state_nxt = S_EMIT;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_nxt  = S_DRN_OUT;
        end
      end
      S_DRN_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_code = ST_GIVEN;
          cmd.out_data = 1'b1;
          cmd.out_last = stat.drn_last;
          cmd.idx_inc  = 1'b1;
          if (stat.drn_last) begin
            cmd.qclear = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_DRN_RD;
          end
        end
      end
      S_EMIT: begin
        // Single status-only result.
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_code = code_r;
          cmd.out_last = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/lq_datapath.sv
// ----------------------------------------------------------------------------
// lq_datapath
// Entry memory as a circular buffer, queue counters, scan index and the
// result output register.
// ----------------------------------------------------------------------------
module lq_datapath (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lq_pkg::dp_cmd_t         cmd,
  output lq_pkg::dp_stat_t        stat,
  input  logic [lq_pkg::FLW-1:0]  in_flight,
  input  logic [lq_pkg::TAGW-1:0] in_payload,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [lq_pkg::STW-1:0]  out_status,
  output logic [lq_pkg::FLW-1:0]  out_flight,
  output logic [lq_pkg::TAGW-1:0] out_payload,
  output logic                    out_last
);
  import lq_pkg::*;

  // Logical queue position to memory address, wrapping at the depth.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [AW:0] s;
    s = (AW+1)'(base) + (AW+1)'(off);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  entry_t          mem [DEPTH];
  entry_t          rd_data_r;
  entry_t          moved_r;
  entry_t          wr_data;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   uc_r, uc_nxt;
  logic [CW-1:0]   idx_r, cmp_idx_r, j_r;
  logic            srch_vld_r;
  logic [FLW-1:0]  flight_r;
  logic [TAGW-1:0] payload_r;
  logic            out_valid_r;
  status_t         status_r;
  logic [FLW-1:0]  flight_out_r;
  logic [TAGW-1:0] payload_out_r;
  logic            last_r;

  // Address and write data selection.
  always_comb begin
    case (cmd.rd_sel)
      RD_JM1:  rd_addr = phys(head_r, j_r - CW'(1));
      default: rd_addr = phys(head_r, idx_r);
    endcase
    case (cmd.wr_sel)
      WR_J: begin
        wr_addr = phys(head_r, j_r);
        wr_data = rd_data_r;
      end
      WR_URG: begin
        wr_addr = phys(head_r, uc_r);
        wr_data = moved_r;
      end
      default: begin
        wr_addr        = phys(head_r, count_r);
        wr_data.flight = flight_r;
        wr_data.tag    = payload_r;
      end
    endcase
  end

  // Entry memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Queue counters and head pointer.
  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    uc_nxt    = uc_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + CW'(1);
    end
    if (cmd.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
      if (uc_r != '0) begin
        uc_nxt = uc_r - CW'(1);
      end
    end
    if (cmd.uc_inc) begin
      uc_nxt = uc_r + CW'(1);
    end
    if (cmd.qclear) begin
      count_nxt = '0;
      uc_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      uc_r       <= '0;
      srch_vld_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      uc_r       <= uc_nxt;
      srch_vld_r <= cmd.srch_rd;
    end
  end

  // Command operands, scan index and shift pointer.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      flight_r  <= in_flight;
      payload_r <= in_payload;
      idx_r     <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.srch_rd) begin
      cmp_idx_r <= idx_r;
    end
    if (cmd.grab) begin
      j_r     <= cmp_idx_r;
      moved_r <= rd_data_r;
    end else if (cmd.j_dec) begin
      j_r <= j_r - CW'(1);
    end
  end

  // Result output register; it frees up in the cycle its transfer completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status_r      <= cmd.out_code;
      flight_out_r  <= cmd.out_data ? rd_data_r.flight : '0;
      payload_out_r <= cmd.out_data ? rd_data_r.tag : '0;
      last_r        <= cmd.out_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_flight  = flight_out_r;
  assign out_payload = payload_out_r;
  assign out_last    = last_r;

  // Status toward the controller.
  always_comb begin
    stat.empty        = (count_r == '0);
    stat.full         = (count_r == CW'(DEPTH));
    stat.idx_lt_count = (idx_r < count_r);
    stat.srch_vld     = srch_vld_r;
    stat.srch_hit     = srch_vld_r && (rd_data_r.flight == flight_r);
    stat.hit_urgent   = (cmp_idx_r < uc_r);
    stat.j_gt_uc      = (j_r > uc_r);
    stat.drn_last     = ((idx_r + CW'(1)) == count_r);
    stat.out_free     = !out_valid_r || out_ready;
  end

endmodule

FILE: rtl/lq_checker.sv
// ----------------------------------------------------------------------------
// lq_checker
// Port-level checks for the landing queue, bound to the top level.
// ----------------------------------------------------------------------------
module lq_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [lq_pkg::STW-1:0]  out_status,
  input logic [lq_pkg::FLW-1:0]  out_flight,
  input logic [lq_pkg::TAGW-1:0] out_payload,
  input logic                    out_last
);
  import lq_pkg::*;

  logic [1:0] pending_r;
  logic       in_xfer, last_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign last_xfer = out_valid && out_ready && out_last;

  // Commands accepted whose final result has not yet transferred.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_xfer) - 2'(last_xfer);
    end
  end

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_status, out_flight, out_payload, out_last}))
    else $error("result changed while stalled");

  // Status-only results carry zero data and close their command.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_GIVEN) |->
      (out_flight == '0) && (out_payload == '0) && out_last)
    else $error("status-only result carries data or is not last");

  // No final result without a command in work.
  a_no_extra_last: assert property (@(posedge clk) disable iff (!rst_n)
    last_xfer |-> (pending_r != 2'd0))
    else $error("final result with no command pending");

  // At most one finished and one running command at a time.
  a_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == 2'd2) |-> !in_ready)
    else $error("command accepted with two pending");

  // An accepted command keeps the input closed in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input ready right after a transfer");

endmodule

bind landing_queue_with_urgent_promotion lq_checker u_lq_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_status  (out_ch.status),
  .out_flight  (out_ch.out_flight),
  .out_payload (out_ch.out_payload),
  .out_last    (out_ch.last)
);

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the landing queue with urgent promotion. Commands
// go in over the input channel with random gaps. A scoreboard keeps its own
// copy of the queue and the urgent section, and derives the results that each
// accepted command must produce. The result channel stalls at random, once
// for a long stretch, and every result is checked field by field in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lq_pkg::*;

  // One result transfer as the queue must produce it.
  typedef struct packed {
    status_t         status;
    logic [FLW-1:0]  flight;
    logic [TAGW-1:0] tag;
    logic            last;
  } landing_result_t;

  // Shadow of the landing queue plus the results still owed by the block.
  class landing_scoreboard;
    entry_t          slots[DEPTH];
    int unsigned     queued;
    int unsigned     urgent;
    landing_result_t owed[$];
    int unsigned     errors;

    function new();
      queued = 0;
      urgent = 0;
      errors = 0;
    endfunction

    function void owe(status_t st, logic [FLW-1:0] fl, logic [TAGW-1:0] tag, logic lst);
      landing_result_t r;
      r.status = st;
      r.flight = fl;
      r.tag    = tag;
      r.last   = lst;
      owed.push_back(r);
    endfunction

    // Apply one accepted command to the shadow queue and queue its results.
    function void note_command(opcode_t op, logic [FLW-1:0] fl, logic [TAGW-1:0] tag);
      entry_t      moved;
      int unsigned hit;
      case (op)
        OP_REQUEST: begin
          if (queued >= DEPTH) begin
            owe(ST_FULL, '0, '0, 1'b1);
          end else begin
            slots[queued].flight = fl;
            slots[queued].tag    = tag;
            queued++;
            owe(ST_NONE, '0, '0, 1'b1);
          end
        end
        OP_CLEAR: begin
          if (queued == 0) begin
            owe(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            owe(ST_GIVEN, slots[0].flight, slots[0].tag, 1'b1);
            for (int i = 1; i < queued; i++) slots[i-1] = slots[i];
            queued--;
            if (urgent > 0) urgent--;
          end
        end
        OP_PROMOTE: begin
          // The first entry with this flight number decides.
          hit = queued;
          for (int i = 0; i < queued; i++) begin
            if (slots[i].flight == fl) begin
              hit = i;
              break;
            end
          end
          if (hit < queued && hit >= urgent) begin
            moved = slots[hit];
            for (int j = hit; j > urgent; j--) slots[j] = slots[j-1];
            slots[urgent] = moved;
            urgent++;
          end
          owe(ST_NONE, '0, '0, 1'b1);
        end
        default: begin
          if (queued == 0) begin
            owe(ST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < queued; i++)
              owe(ST_GIVEN, slots[i].flight, slots[i].tag, (i + 1 == queued));
            queued = 0;
            urgent = 0;
          end
        end
      endcase
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(status_t st, logic [FLW-1:0] fl, logic [TAGW-1:0] tag,
                               logic lst);
      landing_result_t r;
      if (owed.size() == 0) begin
        $error("unexpected result: status %0d flight %0d payload %h last %0d",
               st, fl, tag, lst);
        errors++;
        return;
      end
      r = owed.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (fl !== r.flight) begin
        $error("out_flight: expected %0d, actual %0d", r.flight, fl);
        errors++;
      end
      if (tag !== r.tag) begin
        $error("out_payload: expected %h, actual %h", r.tag, tag);
        errors++;
      end
      if (lst !== r.last) begin
        $error("last: expected %0d, actual %0d", r.last, lst);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  lq_in_if  in_ch();
  lq_out_if out_ch();

  landing_queue_with_urgent_promotion i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  landing_scoreboard sb = new();

  // Sender pacing and the handshake that asks the receiver for a long hold.
  bit          sender_burst;
  int unsigned hold_asked;
  int unsigned hold_served;

  // Clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hold reset at the start, then release it.
  initial begin
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Offer one command after a random gap and wait for its transfer.
  task automatic send_command(opcode_t op, logic [FLW-1:0] fl, logic [TAGW-1:0] tag);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.opcode  <= op;
    in_ch.flight  <= fl;
    in_ch.payload <= tag;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(op, fl, tag);
  endtask

  // Hold the sender until every owed result has come back.
  task automatic wait_results_done();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Flight number for a new request: mostly in range, some duplicates, some wide.
  function automatic logic [FLW-1:0] pick_request_flight();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r < 2) return FLW'($urandom_range(0, 7));
    if (r == 2) return FLW'($urandom_range(0, 16383));
    return FLW'($urandom_range(0, 9999));
  endfunction

  // Flight number to promote: usually one that is queued, else anything.
  function automatic logic [FLW-1:0] pick_promote_flight();
    if (sb.queued > 0 && $urandom_range(0, 3) != 0)
      return sb.slots[$urandom_range(0, sb.queued - 1)].flight;
    return FLW'($urandom_range(0, 16383));
  endfunction

  // Result receiver: random stalls, one long hold on request.
  initial begin
    int unsigned gap;
    bit          burst;
    burst        = 1'b0;
    hold_served  = 0;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if (hold_asked != hold_served) begin
        gap = 300;
        hold_served = hold_asked;
      end else if (burst) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 18);
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(status_t'(out_ch.status), out_ch.out_flight, out_ch.out_payload,
                      out_ch.last);
    end
  end

  // Stimulus: directed cases, a fill to capacity, then random traffic.
  initial begin
    int unsigned bias;
    int unsigned r;
    hold_asked    = 0;
    sender_burst  = 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.opcode  <= OP_REQUEST;
    in_ch.flight  <= '0;
    in_ch.payload <= '0;
    @(posedge rst_n);
    @(posedge clk);

    // Empty queue: drain and cleared both report empty.
    send_command(OP_DRAIN, 14'd0, 32'd0);
    send_command(OP_CLEAR, 14'd0, 32'd0);

    // Field extremes, a flight above range, and a duplicate flight number.
    send_command(OP_REQUEST, 14'd0, 32'h0000_0000);
    send_command(OP_REQUEST, 14'h3FFF, 32'hFFFF_FFFF);
    send_command(OP_REQUEST, 14'd9999, 32'hA5A5_A5A5);
    send_command(OP_REQUEST, 14'd5, 32'h5A5A_5A5A);
    send_command(OP_REQUEST, 14'd5, 32'h0000_0001);

    // Promotions: absent, a real move, already urgent, another move, and a hit at the boundary.
    send_command(OP_PROMOTE, 14'd1234, 32'hFFFF_FFFF);
    send_command(OP_PROMOTE, 14'd5, 32'd0);
    send_command(OP_PROMOTE, 14'd5, 32'd0);
    send_command(OP_PROMOTE, 14'h3FFF, 32'd0);
    send_command(OP_PROMOTE, 14'd0, 32'd0);

    // Cleared with an urgent head, then drain what is left.
    send_command(OP_CLEAR, 14'd0, 32'd0);
    send_command(OP_DRAIN, 14'd0, 32'd0);

    // Fill to capacity with quick back-to-back transfers, then one rejected request.
    sender_burst = 1'b1;
    for (int i = 0; i < DEPTH; i++) send_command(OP_REQUEST, 14'(100 + i), $urandom);
    sender_burst = 1'b0;
    send_command(OP_REQUEST, 14'd77, $urandom);

    // Promote the tail entry across the whole queue, then one right at the urgent boundary.
    send_command(OP_PROMOTE, 14'(100 + DEPTH - 1), 32'd0);
    send_command(OP_PROMOTE, 14'd100, 32'd0);
    send_command(OP_CLEAR, 14'd0, 32'd0);
    send_command(OP_DRAIN, 14'd0, 32'd0);
    wait_results_done();

    // Random traffic in blocks of 10, each with its own mix and pacing.
    for (int blk = 0; blk < 5; blk++) begin
      bias         = $urandom_range(0, 2);
      sender_burst = ($urandom_range(0, 2) == 0);
      if (blk == 2) hold_asked++;
      for (int n = 0; n < 10; n++) begin
        r = $urandom_range(0, 99);
        if (bias == 0) begin
          // Mostly requests so the queue fills up and gets rejected.
          if (r < 70) send_command(OP_REQUEST, pick_request_flight(), $urandom);
          else if (r < 82) send_command(OP_PROMOTE, pick_promote_flight(), $urandom);
          else if (r < 97) send_command(OP_CLEAR, FLW'($urandom_range(0, 16383)), $urandom);
          else send_command(OP_DRAIN, FLW'($urandom_range(0, 16383)), $urandom);
        end else begin
          if (r < 40) send_command(OP_REQUEST, pick_request_flight(), $urandom);
          else if (r < 70) send_command(OP_PROMOTE, pick_promote_flight(), $urandom);
          else if (r < 93) send_command(OP_CLEAR, FLW'($urandom_range(0, 16383)), $urandom);
          else send_command(OP_DRAIN, FLW'($urandom_range(0, 16383)), $urandom);
        end
      end
      if (blk == 3) wait_results_done();
    end

    // Flush whatever is still queued so the last entries are checked as well.
    send_command(OP_DRAIN, 14'd0, 32'd0);
    wait_results_done();
    repeat (40) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
